// ----- hdl/src_pkg.sv -----
// ----------------------------------------------------------------------------
// src_pkg
// Shared types and codes for the stereo rate converter.
// ----------------------------------------------------------------------------
package src_pkg;

   localparam int unsigned SAMPLE_W = 16;

   // action codes carried on the request channel
   localparam logic [1:0] ACT_SAMPLE  = 2'd0;
   localparam logic [1:0] ACT_RESTART = 2'd1;
   localparam logic [1:0] ACT_PAUSE   = 2'd2;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } src_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last;
   } src_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_FIX
   } src_state_type;

   // controller to datapath
   typedef struct packed {
      logic take_sample;
      logic restart;
      logic pause;
      logic step;
      logic mul_a;
      logic mul_b;
      logic mul_c;
      logic load_out;
      logic last;
   } src_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic phase_ge;
      logic phase_ge_next;
      logic out_free;
   } src_status_type;

endpackage

// ----- hdl/stereo_rate_converter_44k1_to_48k.sv -----
// ----------------------------------------------------------------------------
// stereo_rate_converter_44k1_to_48k
// Each sample beat is taken in idle and yields one or two result pairs at
//   44.1 to 48 kHz. For each result the phase check and the four lane steps
//   (three multiplies, one correction) run; the last step loads the result
//   register and stalls while it is still held. A new request beat is taken
//   only once the last result of the beat is loaded; restart and pause act in idle.
// Reset: clears history, phase and both handshakes; no clearing pass.
// ----------------------------------------------------------------------------
module stereo_rate_converter_44k1_to_48k #(
   parameter int unsigned IN_RATE_HZ  = 44100,
   parameter int unsigned OUT_RATE_HZ = 48000
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel: one beat per sample pair or control action
   input  logic                 req_valid,
   output logic                 req_ready,
   input  src_pkg::src_req_type req_data,
   // result channel: one beat per interpolated pair
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output src_pkg::src_rsp_type rsp_data
);
   import src_pkg::*;

   src_cmd_type    cmd;
   src_status_type status;

   // The controller owns sequencing only: it takes a request beat in idle,
   // walks the phase check and the four lane steps for each result, and
   // stalls in the last step while the result register is still held.
   src_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .action    (req_data.action),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the previous and current pairs, the phase
   // accumulator, one interpolation lane per channel and the result
   // register, which decouples the result side so a finished beat can
   // wait while the next request is taken.
   src_datapath #(
      .IN_RATE_HZ  (IN_RATE_HZ),
      .OUT_RATE_HZ (OUT_RATE_HZ)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .left_in   (req_data.left_in),
      .right_in  (req_data.right_in),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/src_lane.sv -----
// ----------------------------------------------------------------------------
// src_lane
// One channel of interpolation: prev + (cur - prev) * num / IN_RATE_HZ,
// truncated toward zero, in four sequenced steps.
// ----------------------------------------------------------------------------
module src_lane #(
   parameter int unsigned IN_RATE_HZ
) (
   input  logic                                 clock,
   input  src_pkg::src_cmd_type                 cmd,
   input  logic signed [src_pkg::SAMPLE_W-1:0]  prev,
   input  logic signed [src_pkg::SAMPLE_W-1:0]  cur,
   input  logic [$clog2(IN_RATE_HZ+1)-1:0]      num,
   output logic signed [src_pkg::SAMPLE_W-1:0]  result
);
   import src_pkg::*;

   localparam int unsigned NUM_W = $clog2(IN_RATE_HZ + 1);
   localparam int unsigned Q_W   = SAMPLE_W;
   localparam int unsigned MAG_W = Q_W + NUM_W;
   localparam int unsigned R_W   = MAG_W - $clog2(IN_RATE_HZ) + 1;
   localparam int unsigned P_W   = MAG_W + R_W;
   localparam int unsigned SUM_W = SAMPLE_W + 2;
   localparam longint unsigned RECIP_L = (64'd1 << MAG_W) / IN_RATE_HZ;
   localparam logic [R_W-1:0]  RECIP   = R_W'(RECIP_L);

   logic signed [SAMPLE_W:0]  diff;
   logic [Q_W-1:0]            dmag;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [P_W-1:0]            qprod;
   logic [Q_W-1:0]            qe_ff, qe_in;
   logic [MAG_W-1:0]          qin_ff, qin_in;
   logic signed [SUM_W-1:0]   base_ff, base_in;
   logic signed [SUM_W-1:0]   qz, qs;
   logic [MAG_W-1:0]          rem;
   logic signed [SUM_W-1:0]   sum;

   always_comb begin
      // step A: magnitude of the difference times the phase weight
      diff   = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
      neg_in = diff[SAMPLE_W];
      dmag   = neg_in ? Q_W'(-diff) : Q_W'(diff);
      mag_in = MAG_W'(dmag) * MAG_W'(num);

      // step B: quotient estimate by reciprocal, low by at most one
      qprod = P_W'(mag_ff) * P_W'(RECIP);
      qe_in = qprod[MAG_W +: Q_W];

      // step C: back-multiply, and form prev plus signed estimate
      qin_in  = MAG_W'(qe_ff) * MAG_W'(IN_RATE_HZ);
      qz      = $signed(SUM_W'(qe_ff));
      qs      = neg_ff ? -qz : qz;
      base_in = SUM_W'(prev) + qs;

      // step D: bump the quotient by one where the remainder is too large
      rem = mag_ff - qin_ff;
      if (rem >= MAG_W'(IN_RATE_HZ)) begin
         sum = neg_ff ? (base_ff - SUM_W'(1)) : (base_ff + SUM_W'(1));
      end else begin
         sum = base_ff;
      end
      result = sum[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_a) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (cmd.mul_b) begin
         qe_ff <= qe_in;
      end
      if (cmd.mul_c) begin
         qin_ff  <= qin_in;
         base_ff <= base_in;
      end
   end

endmodule

// ----- hdl/src_datapath.sv -----
// ----------------------------------------------------------------------------
// src_datapath
// Sample history, phase accumulator, two interpolation lanes and the
// result register.
// ----------------------------------------------------------------------------
module src_datapath #(
   parameter int unsigned IN_RATE_HZ,
   parameter int unsigned OUT_RATE_HZ
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  src_pkg::src_cmd_type                 cmd,
   input  logic signed [src_pkg::SAMPLE_W-1:0]  left_in,
   input  logic signed [src_pkg::SAMPLE_W-1:0]  right_in,
   output src_pkg::src_status_type              status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output src_pkg::src_rsp_type                 rsp_data
);
   import src_pkg::*;

   localparam int unsigned NUM_W   = $clog2(IN_RATE_HZ + 1);
   localparam int unsigned PHASE_W = $clog2(IN_RATE_HZ + OUT_RATE_HZ);

   logic signed [SAMPLE_W-1:0] held_left_ff, held_right_ff;
   logic signed [SAMPLE_W-1:0] prev_left_ff, prev_right_ff;
   logic [PHASE_W-1:0]         phase_ff, phase_sub;
   logic [NUM_W-1:0]           num_ff, num_in;
   logic                       rsp_valid_ff;
   src_rsp_type                rsp_ff;
   logic signed [SAMPLE_W-1:0] lane_left, lane_right;

   always_comb begin
      phase_sub            = phase_ff - PHASE_W'(IN_RATE_HZ);
      status.phase_ge      = (phase_ff >= PHASE_W'(IN_RATE_HZ));
      status.phase_ge_next = status.phase_ge && (phase_sub >= PHASE_W'(IN_RATE_HZ));
      status.out_free      = !rsp_valid_ff || rsp_ready;
      // weight of the current sample; zero while another output is pending
      num_in = status.phase_ge_next ? '0 : NUM_W'(PHASE_W'(IN_RATE_HZ) - phase_sub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_left_ff  <= '0;
         held_right_ff <= '0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.take_sample) begin
            held_left_ff  <= left_in;
            held_right_ff <= right_in;
            phase_ff      <= phase_ff + PHASE_W'(OUT_RATE_HZ);
         end
         if (cmd.restart) begin
            held_left_ff  <= '0;
            held_right_ff <= '0;
            phase_ff      <= '0;
         end
         if (cmd.pause) begin
            phase_ff <= '0;
         end
         if (cmd.step) begin
            phase_ff <= phase_sub;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         prev_left_ff  <= held_left_ff;
         prev_right_ff <= held_right_ff;
      end
      if (cmd.step) begin
         num_ff <= num_in;
      end
      if (cmd.load_out) begin
         rsp_ff.left_out  <= lane_left;
         rsp_ff.right_out <= lane_right;
         rsp_ff.last      <= cmd.last;
      end
   end

   src_lane #(
      .IN_RATE_HZ (IN_RATE_HZ)
   ) u_lane_left (
      .clock  (clock),
      .cmd    (cmd),
      .prev   (prev_left_ff),
      .cur    (held_left_ff),
      .num    (num_ff),
      .result (lane_left)
   );

   src_lane #(
      .IN_RATE_HZ (IN_RATE_HZ)
   ) u_lane_right (
      .clock  (clock),
      .cmd    (cmd),
      .prev   (prev_right_ff),
      .cur    (held_right_ff),
      .num    (num_ff),
      .result (lane_right)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_num_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_a |-> (num_ff <= NUM_W'(IN_RATE_HZ)))
      else $error("interpolation weight above input rate");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result register overwritten while held");
`endif

endmodule

// ----- hdl/src_ctrl.sv -----
// ----------------------------------------------------------------------------
// src_ctrl
// Sequencer: decode the action, step the phase, run the lane steps and
// hand each result to the output register.
// ----------------------------------------------------------------------------
module src_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              action,
   input  src_pkg::src_status_type status,
   output src_pkg::src_cmd_type    cmd
);
   import src_pkg::*;

   src_state_type state_ff, state_in;
   logic          last_ff, last_in;
   logic          emitted_ff, emitted_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         last_ff    <= 1'b0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         last_ff    <= last_in;
         emitted_ff <= emitted_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      last_in    = last_ff;
      emitted_in = emitted_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.last   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               emitted_in = 1'b0;
               unique case (action)
                  ACT_SAMPLE: begin
                     cmd.take_sample = 1'b1;
                     state_in        = ST_CHECK;
                  end
                  ACT_RESTART: cmd.restart = 1'b1;
                  ACT_PAUSE:   cmd.pause   = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (status.phase_ge) begin
               cmd.step = 1'b1;
               last_in  = !status.phase_ge_next || emitted_ff;
               state_in = ST_MUL_A;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_c = 1'b1;
            state_in  = ST_FIX;
         end
         ST_FIX: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               emitted_in   = 1'b1;
               state_in     = last_ff ? ST_IDLE : ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !status.phase_ge)
      else $error("phase left at or above input rate when idle");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && !cmd.last) |=> status.phase_ge)
      else $error("non-final result without a pending output");

   a_second_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && emitted_ff) |-> cmd.last)
      else $error("more than two results for one sample");
`endif

endmodule

// ----- verif/stereo_rate_converter_44k1_to_48k_test.sv -----
// ----------------------------------------------------------------------------
// stereo_rate_converter_44k1_to_48k_test
// Self-checking bench for the 44.1 to 48 kHz stereo interpolator. A queue of
// request beats (directed corner cases, then random traffic) feeds a clocked
// driver. Every accepted beat runs through a behavioural converter that
// produces the expected result pairs. A clocked monitor checks each result
// beat against the oldest expected pair. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stereo_rate_converter_44k1_to_48k_test;
   timeunit 1ns;
   timeprecision 1ps;

   import src_pkg::*;

   localparam int IN_RATE_HZ      = 44100;
   localparam int OUT_RATE_HZ     = 48000;
   localparam int RANDOM_BEATS    = 985;   // beats that the block acts on
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 150;   // result beats seen before the hold-off
   localparam int SETTLE_CYCLES   = 20;
   localparam int MAX_REPORTS     = 10;

   // code that the block ignores; not named in the package
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   src_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   src_rsp_type rsp_data;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stereo_rate_converter_44k1_to_48k #(
      .IN_RATE_HZ  (IN_RATE_HZ),
      .OUT_RATE_HZ (OUT_RATE_HZ)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // beats waiting to be offered, and pairs the converter is owed
   src_req_type pending_beats[$];
   src_rsp_type expected_pairs[$];

   // behavioural copy of the converter state: last pair taken and the phase
   logic signed [15:0] hist_left  = '0;
   logic signed [15:0] hist_right = '0;
   int                 phase_now  = 0;

   int          beats_planned = 0;
   int          beats_taken   = 0;
   int          pairs_seen    = 0;
   int          mismatches    = 0;
   int          hold_cycles   = 0;
   bit          hold_done     = 1'b0;
   src_rsp_type want_pair;

   // One lane: prev + (cur - prev) * weight / IN_RATE_HZ. Work at 64 bits so
   // the product cannot wrap; SystemVerilog division truncates toward zero.
   function automatic logic signed [15:0] blend(input logic signed [15:0] prev,
                                                input logic signed [15:0] cur,
                                                input longint weight);
      longint delta;
      delta = (longint'(cur) - longint'(prev)) * weight;
      return 16'(longint'(prev) + delta / IN_RATE_HZ);
   endfunction

   // Advance the behavioural converter by one accepted beat and queue the
   // pairs it owes, the final one marked as last.
   task automatic advance_converter(input src_req_type beat);
      src_rsp_type        made[2];
      logic signed [15:0] prev_l;
      logic signed [15:0] prev_r;
      longint             weight;
      int                 n;
      n = 0;
      case (beat.action)
         ACT_RESTART: begin
            hist_left  = '0;
            hist_right = '0;
            phase_now  = 0;
         end
         ACT_PAUSE: begin
            phase_now = 0;
         end
         ACT_SAMPLE: begin
            prev_l     = hist_left;
            prev_r     = hist_right;
            hist_left  = beat.left_in;
            hist_right = beat.right_in;
            phase_now += OUT_RATE_HZ;
            // at most two output pairs per beat; any excess phase carries over
            while (phase_now >= IN_RATE_HZ && n < 2) begin
               phase_now -= IN_RATE_HZ;
               // clamp the weight: a pair with another one pending repeats prev
               weight = IN_RATE_HZ - phase_now;
               if (weight < 0)
                  weight = 0;
               if (weight > IN_RATE_HZ)
                  weight = IN_RATE_HZ;
               made[n].left_out  = blend(prev_l, hist_left, weight);
               made[n].right_out = blend(prev_r, hist_right, weight);
               n++;
            end
            for (int k = 0; k < n; k++) begin
               made[k].last = (k == n - 1);
               expected_pairs.push_back(made[k]);
            end
         end
         default: ;  // unused code: drop without touching the state
      endcase
   endtask

   task automatic flag_pair(input string tag, input src_rsp_type want,
                            input src_rsp_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                  tag, want.left_out, want.right_out, want.last,
                  got.left_out, got.right_out, got.last);
   endtask

   task automatic queue_beat(input logic [1:0] act, input logic [15:0] l,
                             input logic [15:0] r);
      src_req_type beat;
      beat.action   = act;
      beat.left_in  = l;
      beat.right_in = r;
      pending_beats.push_back(beat);
      beats_planned++;
   endtask

   // Mostly full-range noise, with a share of extremes and of small values so
   // that neighbouring samples also land close together.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0, 1: begin
            case ($urandom_range(3))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         2, 3:    return 16'($signed($urandom_range(127)) - 64);
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus: fill the beat queue, release reset, then wait for the block to
   // drain and report.
   // ------------------------------------------------------------------------
   initial begin
      int         useful;
      int         roll;
      logic [1:0] act;

      // full-scale steps both ways, starting from the cleared history
      queue_beat(ACT_SAMPLE, 16'h7FFF, 16'h8000);
      queue_beat(ACT_SAMPLE, 16'h8000, 16'h7FFF);
      queue_beat(ACT_SAMPLE, 16'h7FFF, 16'h7FFF);
      queue_beat(ACT_SAMPLE, 16'h8000, 16'h8000);
      // restart with a busy payload: the payload must be ignored
      queue_beat(ACT_RESTART, 16'h5A5A, 16'hA5A5);
      queue_beat(ACT_SAMPLE, 16'h0000, 16'h0000);
      // pause keeps the history, clears only the phase
      queue_beat(ACT_PAUSE, 16'hFFFF, 16'h8001);
      queue_beat(ACT_SAMPLE, 16'hFFFF, 16'h0001);
      // unused code with every payload bit set: no state change, no pair
      queue_beat(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
      // walk the phase up by 3900 a beat until one beat yields two pairs
      for (int i = 0; i < 12; i++)
         queue_beat(ACT_SAMPLE, i[0] ? 16'h8000 : 16'h7FFF,
                    i[0] ? 16'h7FFF : 16'h8000);
      queue_beat(ACT_RESTART, 16'h0000, 16'h0000);

      // random traffic: mostly samples, with restarts, pauses and unused codes
      useful = 0;
      while (useful < RANDOM_BEATS) begin
         roll = $urandom_range(99);
         if (roll < 4)
            act = ACT_RESTART;
         else if (roll < 9)
            act = ACT_PAUSE;
         else if (roll < 13)
            act = ACT_UNUSED;
         else
            act = ACT_SAMPLE;
         queue_beat(act, pick_sample(), pick_sample());
         if (act != ACT_UNUSED)
            useful++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // hold until every beat is taken and every owed pair has come back
      while (beats_taken != beats_planned) @(posedge clock);
      while (expected_pairs.size() != 0) @(posedge clock);
      // allow the pipeline to flush anything unexpected
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // generous ceiling on the run time
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: predict on each accepted beat, then offer the next beat unless
   // idling. A stretch of beats is sent back to back.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_converter(req_data);
            beats_taken++;
         end
         // only move on once the current beat has gone (or none is held)
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 &&
                ((beats_taken >= 400 && beats_taken < 650) ||
                 $urandom_range(99) >= 22)) begin
               req_data  <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Hold-off counter: once enough pairs have come back, count out a long
   // stretch during which the receiver stalls, so the block backs up.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && pairs_seen >= HOLD_OFF_AT) begin
         hold_done   <= 1'b1;
         hold_cycles <= HOLD_OFF_CYCLES;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each result beat against the oldest owed pair and steer
   // rsp_ready. Hold ready low while the hold-off counter runs; later, a
   // stretch with ready held high.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pairs_seen++;
            if (expected_pairs.size() == 0) begin
               flag_pair("unexpected pair", '0, rsp_data);
            end else begin
               want_pair = expected_pairs.pop_front();
               if (want_pair !== rsp_data)
                  flag_pair("pair mismatch", want_pair, rsp_data);
            end
         end
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (pairs_seen >= 700 && pairs_seen < 900) ||
                         $urandom_range(99) >= 22;
         end
      end
   end

endmodule

// ----- filelist.f -----
hdl/src_pkg.sv
hdl/src_lane.sv
hdl/src_datapath.sv
hdl/src_ctrl.sv
hdl/stereo_rate_converter_44k1_to_48k.sv
verif/stereo_rate_converter_44k1_to_48k_test.sv
